>>> hw/rtl/mrcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcc_pkg
// Shared widths, operation codes and register indexes of the mixed-radix
// candidate counter.
// ----------------------------------------------------------------------------
package mrcc_pkg;

   localparam int OP_W        = 2;
   localparam int ADDR_W      = 8;
   localparam int VALUE_W     = 8;
   localparam int STEP_W      = 31;
   localparam int SUM_W       = 32;
   localparam int RADIX_W     = 9;
   localparam int LEN_W       = 7;
   localparam int DIGIT_W     = 8;
   localparam int CHAR_W      = 8;
   localparam int POS_W       = 6;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_SET     = 2'd1;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_LENGTH = 4'd1;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd26;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
   localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd8;

   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

>>> hw/rtl/mrcc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcc_req_if
// Request channel: operation, address, value and step amount.
// ----------------------------------------------------------------------------
interface mrcc_req_if import mrcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [ADDR_W-1:0]  address;
   logic [VALUE_W-1:0] value;
   logic [STEP_W-1:0]  step_amount;

   modport source (output valid, output operation, output address, output value,
                   output step_amount, input ready);
   modport sink   (input valid, input operation, input address, input value,
                   input step_amount, output ready);
endinterface

>>> hw/rtl/mrcc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcc_rsp_if
// Result channel: one digit of the candidate word per transfer.
// ----------------------------------------------------------------------------
interface mrcc_rsp_if import mrcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   digit_position;
   logic [DIGIT_W-1:0] digit_value;
   logic [CHAR_W-1:0]  out_char;
   logic               last;
   logic               wrapped;

   modport source (output valid, output digit_position, output digit_value,
                   output out_char, output last, output wrapped, input ready);
   modport sink   (input valid, input digit_position, input digit_value,
                   input out_char, input last, input wrapped, output ready);
endinterface

>>> hw/rtl/mrcc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcc_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mrcc_csr_if import mrcc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/mrcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcc_div
// Restoring serial divider, one quotient bit per cycle. Remainder is
// narrow since the divisor never exceeds 256.
// ----------------------------------------------------------------------------
module mrcc_div import mrcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [RADIX_W-1:0] divisor,
   output logic               done,
   output logic [SUM_W-1:0]   quotient,
   output logic [DIGIT_W-1:0] remainder
);

   localparam int CNT_W = $clog2(SUM_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] dvs_ff, dvs_in;
   logic [RADIX_W-1:0] trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = (trial >= dvs_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? DIGIT_W'(trial - dvs_ff) : trial[DIGIT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/mixed_radix_candidate_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_candidate_counter
// Mixed-radix digit vector with character table; advance adds a step with
// carry and streams the new word out one digit per transfer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  req_ch   in   operation, address, value, step_amount            valid/ready
//  rsp_ch   out  digit_position, digit_value, out_char, last, wrapped valid/ready
//  csr_ch   in   index, data                                       valid/ready
//
//  Load and set are written as they are accepted. Advance runs an add/divide
//  pass per digit (read, sum, then the serial divider), then an output
//  pass per digit (read, character lookup, output load, send) that waits
//  on rsp stalls. req_ch is not ready until the last digit is taken.
//  Synchronous reset clears digits to zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module mixed_radix_candidate_counter import mrcc_pkg::*; #(
   parameter int MAX_DIGITS  = 64,
   parameter int TABLE_DEPTH = 256
) (
   input logic          clock,
   input logic          reset,
   mrcc_req_if.sink     req_ch,
   mrcc_rsp_if.source   rsp_ch,
   mrcc_csr_if.sink     csr_ch
);

   localparam int DIGIT_AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_ERD  = 3'd4;
   localparam logic [2:0] S_ECH  = 3'd5;
   localparam logic [2:0] S_ELD  = 3'd6;
   localparam logic [2:0] S_SEND = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff;
   logic [LEN_W-1:0]   len_cfg_ff;
   logic [RADIX_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [SUM_W-1:0]   carry_ff, carry_in;
   logic               wrap_ff, wrap_in;

   digit_type          dig_mem [MAX_DIGITS];
   logic [MAX_DIGITS-1:0] dig_vld_ff;
   digit_type          dig_rd_ff;
   logic               dig_rd_vld_ff;
   digit_type          digit_cur;
   logic               dig_we;
   logic [DIGIT_AW-1:0] dig_waddr;
   digit_type          dig_wdata;

   logic [CHAR_W-1:0]  chr_mem [TABLE_DEPTH];
   logic [CHAR_W-1:0]  chr_rd_ff;
   logic               chr_ok_ff;
   logic               chr_we;

   logic [POS_W-1:0]   out_pos_ff;
   digit_type          out_digit_ff;
   logic [CHAR_W-1:0]  out_char_ff;
   logic               out_last_ff;
   logic               out_wrap_ff;
   logic               out_load;

   logic               req_fire;
   logic               div_start;
   logic               div_done;
   logic [SUM_W-1:0]   div_quo;
   digit_type          div_rem;
   logic [SUM_W-1:0]   sum;
   logic               pos_last;
   logic [RADIX_W-1:0] base_eff;
   logic [LEN_W-1:0]   len_eff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);

   assign base_eff = (radix_ff < RADIX_MIN) ? RADIX_MIN :
                     (radix_ff > RADIX_MAX) ? RADIX_MAX : radix_ff;
   assign len_eff  = (len_cfg_ff == '0) ? LEN_W'(1) :
                     (32'(len_cfg_ff) > MAX_DIGITS) ? LEN_W'(MAX_DIGITS) : len_cfg_ff;

   assign digit_cur = dig_rd_vld_ff ? dig_rd_ff : '0;
   assign sum       = carry_ff + SUM_W'(digit_cur);
   assign pos_last  = ((pos_ff + LEN_W'(1)) == len_ff);

   mrcc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (sum),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      carry_in  = carry_ff;
      wrap_in   = wrap_ff;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_ch.operation == OP_ADVANCE)) begin
               state_in = S_RD;
               carry_in = SUM_W'(req_ch.step_amount);
               base_in  = base_eff;
               len_in   = len_eff;
               pos_in   = '0;
            end
         end
         S_RD: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               carry_in = div_quo;
               if (pos_last) begin
                  wrap_in  = (div_quo != '0);
                  pos_in   = '0;
                  state_in = S_ERD;
               end else begin
                  pos_in   = pos_ff + LEN_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_ERD: begin
            state_in = S_ECH;
         end
         S_ECH: begin
            state_in = S_ELD;
         end
         S_ELD: begin
            out_load = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_ch.ready) begin
               if (out_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + LEN_W'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         radix_ff   <= RADIX_RESET;
         len_cfg_ff <= LEN_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_RADIX:       radix_ff   <= csr_ch.data;
               CSR_WORD_LENGTH: len_cfg_ff <= csr_ch.data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      len_ff   <= len_in;
      pos_ff   <= pos_in;
      carry_ff <= carry_in;
      wrap_ff  <= wrap_in;
   end

   // digit store
   assign dig_we = (req_fire && (req_ch.operation == OP_SET) &&
                    (32'(req_ch.address) < MAX_DIGITS)) ||
                   ((state_ff == S_DIV) && div_done);
   assign dig_waddr = (state_ff == S_DIV) ? pos_ff[DIGIT_AW-1:0]
                                          : req_ch.address[DIGIT_AW-1:0];
   assign dig_wdata = (state_ff == S_DIV) ? div_rem : req_ch.value;

   always_ff @(posedge clock) begin
      if (dig_we) begin
         dig_mem[dig_waddr] <= dig_wdata;
      end
      dig_rd_ff <= dig_mem[pos_ff[DIGIT_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_vld_ff    <= '0;
         dig_rd_vld_ff <= 1'b0;
      end else begin
         if (dig_we) begin
            dig_vld_ff[dig_waddr] <= 1'b1;
         end
         dig_rd_vld_ff <= dig_vld_ff[pos_ff[DIGIT_AW-1:0]];
      end
   end

   // character table
   assign chr_we = req_fire && (req_ch.operation == OP_LOAD) &&
                   (32'(req_ch.address) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (chr_we) begin
         chr_mem[req_ch.address[TABLE_AW-1:0]] <= req_ch.value;
      end
      chr_rd_ff <= chr_mem[digit_cur[TABLE_AW-1:0]];
      chr_ok_ff <= (32'(digit_cur) < TABLE_DEPTH);
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pos_ff   <= pos_ff[POS_W-1:0];
         out_digit_ff <= digit_cur;
         out_char_ff  <= chr_ok_ff ? chr_rd_ff : '0;
         out_last_ff  <= pos_last;
         out_wrap_ff  <= wrap_ff;
      end
   end

   assign rsp_ch.valid          = (state_ff == S_SEND);
   assign rsp_ch.digit_position = out_pos_ff;
   assign rsp_ch.digit_value    = out_digit_ff;
   assign rsp_ch.out_char       = out_char_ff;
   assign rsp_ch.last           = out_last_ff;
   assign rsp_ch.wrapped        = out_wrap_ff;

endmodule

>>> hw/rtl/mrcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcc_checker
// Port-level checks of the candidate counter, bound to the top level.
// ----------------------------------------------------------------------------
module mrcc_checker import mrcc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic [OP_W-1:0] req_operation,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [POS_W-1:0] rsp_digit_position,
   input logic            rsp_last,
   input logic            rsp_wrapped
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("result pending while request channel open");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_position))
      else $error("stalled result dropped or changed");

   a_busy_after_adv: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_ADVANCE) |=> !req_ready)
      else $error("advance did not block the request channel");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("request channel not reopened after last digit");

   a_wrap_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> $stable(rsp_wrapped))
      else $error("wrap flag changed within one word");

endmodule

bind mixed_radix_candidate_counter mrcc_checker u_mrcc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_operation      (req_ch.operation),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_digit_position (rsp_ch.digit_position),
   .rsp_last           (rsp_ch.last),
   .rsp_wrapped        (rsp_ch.wrapped)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mixed-radix candidate counter. The character
// table is filled first, then a directed set of requests runs at the reset
// settings, followed by random requests under a series of radix and word
// length settings. Every accepted request is run through a shadow model of
// the digit vector and table, and the predicted digit stream is compared
// with what the block emits. Sender bursts/gaps and receiver stalls vary.
// ----------------------------------------------------------------------------
module tb;
   import mrcc_pkg::*;

   localparam int MAX_DIGITS    = 64;
   localparam int TABLE_DEPTH   = 256;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 64;
   localparam int N_PHASES      = 12;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [ADDR_W-1:0]  address;
      logic [VALUE_W-1:0] value;
      logic [STEP_W-1:0]  step_amount;
   } request_type;

   typedef struct packed {
      logic [POS_W-1:0]  digit_position;
      digit_type         digit_value;
      logic [CHAR_W-1:0] out_char;
      logic              last;
      logic              wrapped;
   } word_digit_type;

   logic clock;
   logic reset;

   mrcc_req_if req_if ();
   mrcc_rsp_if rsp_if ();
   mrcc_csr_if csr_if ();

   mixed_radix_candidate_counter #(
      .MAX_DIGITS (MAX_DIGITS),
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   // shadow state of the block
   digit_type         shadow_digits [MAX_DIGITS];
   logic [CHAR_W-1:0] shadow_chars  [TABLE_DEPTH];
   logic [RADIX_W-1:0] radix_reg;
   logic [LEN_W-1:0]   length_reg;

   request_type    request_queue [$];
   word_digit_type expected_digits [$];

   int fail_count;
   int count_requests;
   int count_advances;
   int count_wrapped;
   int count_results;
   int count_settings;

   int burst_left;
   int gap_left;
   int stall_ticks;
   logic [7:0] stall_pattern;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int unsigned counting_base();
      if (radix_reg < RADIX_MIN) return RADIX_MIN;
      if (radix_reg > RADIX_MAX) return RADIX_MAX;
      return radix_reg;
   endfunction

   function automatic int unsigned word_positions();
      if (length_reg < 1) return 1;
      if (length_reg > MAX_DIGITS) return MAX_DIGITS;
      return length_reg;
   endfunction

   task automatic predict_request(input request_type r);
      int unsigned    base;
      int unsigned    len;
      int unsigned    carry;
      int unsigned    sum;
      logic           wrap;
      word_digit_type d;
      case (r.operation)
         OP_LOAD: begin
            shadow_chars[r.address] = r.value;
         end
         OP_SET: begin
            if (r.address < MAX_DIGITS) shadow_digits[r.address] = r.value;
         end
         OP_ADVANCE: begin
            base  = counting_base();
            len   = word_positions();
            carry = r.step_amount;
            for (int i = 0; i < len; i++) begin
               sum              = carry + shadow_digits[i];
               shadow_digits[i] = digit_type'(sum % base);
               carry            = sum / base;
            end
            wrap = (carry != 0);
            count_advances++;
            if (wrap) count_wrapped++;
            for (int i = 0; i < len; i++) begin
               d.digit_position = POS_W'(i);
               d.digit_value    = shadow_digits[i];
               d.out_char       = shadow_chars[shadow_digits[i]];
               d.last           = (i == len - 1);
               d.wrapped        = wrap;
               expected_digits.push_back(d);
            end
         end
         default: ;
      endcase
   endtask

   function automatic request_type make_request(logic [OP_W-1:0] op, int unsigned addr,
                                                int unsigned val, int unsigned step);
      request_type r;
      r.operation   = op;
      r.address     = ADDR_W'(addr);
      r.value       = VALUE_W'(val);
      r.step_amount = STEP_W'(step);
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      int unsigned base;
      int unsigned len;
      base          = counting_base();
      len           = word_positions();
      pick          = $urandom_range(0, 99);
      r.address     = ADDR_W'($urandom());
      r.value       = VALUE_W'($urandom());
      r.step_amount = STEP_W'($urandom());
      if (pick < 45) begin
         r.operation = OP_ADVANCE;
         case ($urandom_range(0, 9))
            0:       r.step_amount = '0;
            1:       r.step_amount = '1;
            2, 3, 4: r.step_amount = STEP_W'($urandom_range(1, base));
            5, 6:    r.step_amount = STEP_W'($urandom_range(0, 5000));
            default: ;
         endcase
      end else if (pick < 75) begin
         r.operation = OP_SET;
         if ($urandom_range(0, 4) != 0) r.address = ADDR_W'($urandom_range(0, len - 1));
         if ($urandom_range(0, 9) < 7) r.value = VALUE_W'($urandom_range(0, base - 1));
      end else if (pick < 95) begin
         r.operation = OP_LOAD;
      end else begin
         r.operation = OP_RESERVED;
      end
      return r;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_RADIX) radix_reg = data[RADIX_W-1:0];
      else if (idx == CSR_WORD_LENGTH) length_reg = data[LEN_W-1:0];
   endtask

   // block is quiet: nothing queued, nothing in flight, nothing owed
   task automatic wait_quiet(input int extra);
      do @(posedge clock);
      while (request_queue.size() != 0 || req_if.valid || expected_digits.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic flag_digit(input string what, input word_digit_type want,
                             input word_digit_type got);
      if (fail_count < 10)
         $display({"%s: want pos=%0d digit=%0d char=%02h last=%0b wrap=%0b,",
                   " got pos=%0d digit=%0d char=%02h last=%0b wrap=%0b"},
                  what, want.digit_position, want.digit_value, want.out_char, want.last,
                  want.wrapped, got.digit_position, got.digit_value, got.out_char, got.last,
                  got.wrapped);
      fail_count++;
   endtask

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : drive_requests
      request_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left   <= 0;
         gap_left     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_request(make_request(req_if.operation, req_if.address, req_if.value,
                                         req_if.step_amount));
            count_requests++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               item               = request_queue.pop_front();
               req_if.valid       <= 1'b1;
               req_if.operation   <= item.operation;
               req_if.address     <= item.address;
               req_if.value       <= item.value;
               req_if.step_amount <= item.step_amount;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls follow a rotating pattern that changes now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         stall_ticks   <= 0;
         stall_pattern <= 8'hFF;
      end else begin
         if (stall_ticks == 0) begin
            stall_ticks   <= $urandom_range(16, 96);
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         end else begin
            stall_ticks   <= stall_ticks - 1;
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
         end
         rsp_if.ready <= stall_pattern[0];
      end
   end

   always @(posedge clock) begin : check_digits
      word_digit_type got;
      word_digit_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.digit_position = rsp_if.digit_position;
         got.digit_value    = rsp_if.digit_value;
         got.out_char       = rsp_if.out_char;
         got.last           = rsp_if.last;
         got.wrapped        = rsp_if.wrapped;
         count_results++;
         if (expected_digits.size() == 0) begin
            flag_digit("unexpected digit", '0, got);
         end else begin
            want = expected_digits.pop_front();
            if (got !== want) flag_digit("digit mismatch", want, got);
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_radix  [N_PHASES];
      int unsigned phase_length [N_PHASES];
      int unsigned phase_items  [N_PHASES];
      phase_radix  = '{2, 256, 0, 511, 257, 1, 0, 0, 0, 0, 0, 0};
      phase_length = '{64, 1, 0, 127, 65, 3, 0, 0, 0, 0, 0, 0};
      phase_items  = '{6, 20, 15, 5, 5, 15, 19, 19, 19, 19, 19, 19};

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.operation   = OP_LOAD;
      req_if.address     = '0;
      req_if.value       = '0;
      req_if.step_amount = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_RADIX;
      csr_if.data        = '0;
      radix_reg          = RADIX_RESET;
      length_reg         = LEN_RESET;
      fail_count         = 0;
      count_requests     = 0;
      count_advances     = 0;
      count_wrapped      = 0;
      count_results      = 0;
      count_settings     = 1;
      foreach (shadow_digits[i]) shadow_digits[i] = '0;
      foreach (shadow_chars[i]) shadow_chars[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table so no advance can read an unwritten entry
      for (int i = 0; i < TABLE_DEPTH; i++)
         request_queue.push_back(make_request(OP_LOAD, i, $urandom_range(0, 255), 0));
      wait_quiet(0);

      // directed requests at the reset settings
      request_queue.push_back(make_request(OP_LOAD, 0, 8'h00, 0));
      request_queue.push_back(make_request(OP_LOAD, 255, 8'hFF, 0));
      request_queue.push_back(make_request(OP_ADVANCE, 0, 0, 0));
      request_queue.push_back(make_request(OP_ADVANCE, 0, 0, 1));
      request_queue.push_back(make_request(OP_ADVANCE, 255, 255, 31'h7FFFFFFF));
      request_queue.push_back(make_request(OP_SET, 0, 255, 0));
      request_queue.push_back(make_request(OP_SET, 7, 25, 0));
      request_queue.push_back(make_request(OP_SET, 63, 200, 0));
      request_queue.push_back(make_request(OP_SET, 64, 1, 0));
      request_queue.push_back(make_request(OP_SET, 255, 255, 31'h7FFFFFFF));
      request_queue.push_back(make_request(OP_ADVANCE, 0, 0, 0));
      request_queue.push_back(make_request(OP_RESERVED, 255, 255, 31'h7FFFFFFF));
      request_queue.push_back(make_request(OP_LOAD, 128, 8'hA5, 0));
      request_queue.push_back(make_request(OP_SET, 3, 128, 0));
      request_queue.push_back(make_request(OP_ADVANCE, 0, 0, 26));
      request_queue.push_back(make_request(OP_RESERVED, 0, 0, 0));
      request_queue.push_back(make_request(OP_ADVANCE, 0, 0, 31'h55555555));
      request_queue.push_back(make_request(OP_ADVANCE, 0, 0, 31'h2AAAAAAA));
      wait_quiet(SETTLE_CYCLES);

      for (int p = 0; p < N_PHASES; p++) begin
         if (p >= 6) begin
            phase_radix[p]  = $urandom_range(2, 256);
            phase_length[p] = $urandom_range(1, 12);
         end
         write_register(CSR_RADIX, CSR_DATA_W'(phase_radix[p]));
         write_register(CSR_WORD_LENGTH, CSR_DATA_W'(phase_length[p]));
         count_settings++;
         for (int n = 0; n < phase_items[p]; n++) request_queue.push_back(random_request());
         wait_quiet(SETTLE_CYCLES);
      end

      repeat (END_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d advances, %0d carried out of the top digit,",
               count_requests, count_advances, count_wrapped);
      $display("%0d digits under %0d radix/word length settings, out-of-range values included",
               count_results, count_settings);
      if (expected_digits.size() != 0)
         $display("%0d expected digits never arrived", expected_digits.size());
      if (fail_count == 0 && expected_digits.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("timeout with %0d digits outstanding", expected_digits.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
